/* src/rmd_pkg.sv */
package rmd_pkg;

    localparam int MAX_COPIES_DEF = 8;
    localparam int BYTE_W         = 8;
    localparam int CFG_W          = 4;
    localparam int ERR_W          = 32;

    localparam logic [CFG_W-1:0]  CFG_RESET  = 4'd3;
    localparam logic [BYTE_W-1:0] SPACE_CODE = 8'h20;
    localparam logic [BYTE_W-1:0] PRINT_LOW  = 8'h20;
    localparam logic [BYTE_W-1:0] PRINT_HIGH = 8'h7E;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic accept;   // a byte transfer happens this cycle
        logic shift;    // move every cell one place toward the head
        logic clear;    // drop the partial block
    } t_cell_ctl;

endpackage

/* src/rmd_cell.sv */
module rmd_cell #(
    parameter int CNT_W = $clog2(rmd_pkg::MAX_COPIES_DEF + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  rmd_pkg::t_cell_ctl       i_ctl,
    input  logic [rmd_pkg::BYTE_W-1:0] i_data,
    input  logic [CNT_W-1:0]         i_new_count,
    input  logic                     i_prev_valid,
    input  logic                     i_next_valid,
    input  logic [rmd_pkg::BYTE_W-1:0] i_next_byte,
    input  logic [CNT_W-1:0]         i_next_count,
    output logic                     o_valid,
    output logic [rmd_pkg::BYTE_W-1:0] o_byte,
    output logic [CNT_W-1:0]         o_count,
    output logic [CNT_W-1:0]         o_match_count
);
    import rmd_pkg::*;

    logic               r_valid;
    logic [BYTE_W-1:0]  r_byte;
    logic [CNT_W-1:0]   r_count;
    logic               w_hit;

    assign w_hit = r_valid && (r_byte == i_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_next_valid;
        end else if (i_ctl.accept && !r_valid && i_prev_valid) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_byte  <= i_next_byte;
            r_count <= i_next_count;
        end else if (i_ctl.accept) begin
            if (w_hit) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!r_valid && i_prev_valid) begin
                r_byte  <= i_data;
                r_count <= i_new_count;
            end
        end
    end

    // Count this byte value will hold once the incoming copy is added
    assign o_match_count = w_hit ? r_count + CNT_W'(1) : '0;
    assign o_valid       = r_valid;
    assign o_byte        = r_byte;
    assign o_count       = r_count;

endmodule

/* src/rmd_vote.sv */
module rmd_vote #(
    parameter int CNT_W = $clog2(rmd_pkg::MAX_COPIES_DEF + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_start,
    input  logic                       i_step,
    input  logic [rmd_pkg::BYTE_W-1:0] i_head_byte,
    input  logic [CNT_W-1:0]           i_head_count,
    output logic [rmd_pkg::BYTE_W-1:0] o_best_byte
);
    import rmd_pkg::*;

    logic [BYTE_W-1:0] r_best_byte;
    logic [CNT_W-1:0]  r_best_count;
    logic [BYTE_W-1:0] w_head_key;
    logic [BYTE_W-1:0] w_best_key;
    logic              w_take;

    // Signed byte order: flip the sign bit and compare unsigned
    assign w_head_key = {~i_head_byte[BYTE_W-1], i_head_byte[BYTE_W-2:0]};
    assign w_best_key = {~r_best_byte[BYTE_W-1], r_best_byte[BYTE_W-2:0]};

    assign w_take = (i_head_count > r_best_count) ||
                    ((i_head_count == r_best_count) && (w_head_key < w_best_key));

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_best_count <= '0;
        end else if (i_step && w_take) begin
            r_best_count <= i_head_count;
            r_best_byte  <= i_head_byte;
        end
    end

    assign o_best_byte = r_best_byte;

endmodule

/* src/repetition_majority_decoder.sv */
// Repetition code decoder by majority vote.
// Input channel (i_in_valid / o_in_ready / i_data_byte): one received copy per
// transfer. Copies group into blocks of copies_per_symbol bytes (0 acts as 1,
// values above MAX_COPIES act as MAX_COPIES).
// Config channel (i_cfg_valid / o_cfg_ready / i_copies_per_symbol): sets the
// block length and drops any partial block.
// Output channel (o_out_valid / i_out_ready): one result per complete block:
// the most frequent byte (ties to the smaller signed value), or a space with
// o_not_printable set when the winner is outside 0x20..0x7E, plus the
// saturating total of replaced blocks.
// Timing: while a block is collected the input is ready unless a config write
// is pending, so its copies can enter one per cycle. After the last copy the
// cell chain shifts its n entries past the vote unit, one cell per cycle, and
// the input takes no new copy until the result is loaded.
// A stalled receiver holds the result in the output register; the next block
// streams in meanwhile and waits at its end until the register drains.
// Reset: block length 3, no partial block, error total zero, no result.
module repetition_majority_decoder #(
    parameter int MAX_COPIES = rmd_pkg::MAX_COPIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [rmd_pkg::CFG_W-1:0]   i_copies_per_symbol,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [rmd_pkg::BYTE_W-1:0]  i_data_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [rmd_pkg::BYTE_W-1:0]  o_corrected_byte,
    output logic                        o_not_printable,
    output logic [rmd_pkg::ERR_W-1:0]   o_error_total
);
    import rmd_pkg::*;

    localparam int CNT_W = $clog2(MAX_COPIES + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [CFG_W-1:0]  r_cfg;
    logic [CNT_W-1:0]  r_fill;
    logic [CNT_W-1:0]  r_left;
    logic [ERR_W-1:0]  r_err;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_bad;

    logic [CNT_W-1:0]  w_len;
    logic              w_cfg_xfer;
    logic              w_in_xfer;
    logic              w_last_copy;
    logic              w_finish;
    logic              w_bad;
    t_cell_ctl         w_ctl;
    logic [CNT_W-1:0]  w_new_count;
    logic [BYTE_W-1:0] w_best_byte;

    logic [MAX_COPIES-1:0] w_valid;
    logic [BYTE_W-1:0]     w_byte  [MAX_COPIES];
    logic [CNT_W-1:0]      w_count [MAX_COPIES];
    logic [CNT_W-1:0]      w_match [MAX_COPIES];

    // Effective block length
    always_comb begin
        if (r_cfg == '0) begin
            w_len = CNT_W'(1);
        end else if (int'(r_cfg) > MAX_COPIES) begin
            w_len = CNT_W'(MAX_COPIES);
        end else begin
            w_len = CNT_W'(r_cfg);
        end
    end

    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_in_ready  = (r_state == ST_IDLE) && !i_cfg_valid;
    assign w_cfg_xfer  = i_cfg_valid && o_cfg_ready;
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_last_copy = (r_fill + CNT_W'(1)) == w_len;
    assign w_finish    = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    assign w_ctl.accept = w_in_xfer;
    assign w_ctl.shift  = (r_state == ST_SCAN);
    assign w_ctl.clear  = w_cfg_xfer;

    // Matching cells all hold the same count, so an OR picks it up
    always_comb begin
        w_new_count = '0;
        for (int i = 0; i < MAX_COPIES; i++) begin
            w_new_count = w_new_count | w_match[i];
        end
        if (w_new_count == '0) begin
            w_new_count = CNT_W'(1);
        end
    end

    // Cell chain: a new copy lands in the first empty cell; during the vote
    // every cell hands its entry to the one nearer the head.
    for (genvar g = 0; g < MAX_COPIES; g++) begin : g_cell
        logic              w_prev_valid;
        logic              w_next_valid;
        logic [BYTE_W-1:0] w_next_byte;
        logic [CNT_W-1:0]  w_next_count;

        if (g == 0) begin : g_head
            assign w_prev_valid = 1'b1;
        end else begin : g_body
            assign w_prev_valid = w_valid[g-1];
        end

        if (g == MAX_COPIES - 1) begin : g_tail
            assign w_next_valid = 1'b0;
            assign w_next_byte  = '0;
            assign w_next_count = '0;
        end else begin : g_link
            assign w_next_valid = w_valid[g+1];
            assign w_next_byte  = w_byte[g+1];
            assign w_next_count = w_count[g+1];
        end

        rmd_cell #(
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_data        (i_data_byte),
            .i_new_count   (w_new_count),
            .i_prev_valid  (w_prev_valid),
            .i_next_valid  (w_next_valid),
            .i_next_byte   (w_next_byte),
            .i_next_count  (w_next_count),
            .o_valid       (w_valid[g]),
            .o_byte        (w_byte[g]),
            .o_count       (w_count[g]),
            .o_match_count (w_match[g])
        );
    end

    rmd_vote #(
        .CNT_W (CNT_W)
    ) u_vote (
        .i_clk        (i_clk),
        .i_start      (w_in_xfer && w_last_copy),
        .i_step       (r_state == ST_SCAN),
        .i_head_byte  (w_byte[0]),
        .i_head_count (w_count[0]),
        .o_best_byte  (w_best_byte)
    );

    assign w_bad = (w_best_byte < PRINT_LOW) || (w_best_byte > PRINT_HIGH);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer && w_last_copy) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_left == CNT_W'(1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cfg       <= CFG_RESET;
            r_fill      <= '0;
            r_left      <= '0;
            r_err       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // Block bookkeeping
            if (w_cfg_xfer) begin
                r_cfg  <= i_copies_per_symbol;
                r_fill <= '0;
            end else if (w_in_xfer) begin
                if (w_last_copy) begin
                    r_fill <= '0;
                    r_left <= w_len;
                end else begin
                    r_fill <= r_fill + CNT_W'(1);
                end
            end else if (r_state == ST_SCAN) begin
                r_left <= r_left - CNT_W'(1);
            end
            // Output register: load on finish, drop on transfer
            if (w_finish) begin
                r_out_valid <= 1'b1;
                if (w_bad && (r_err != '1)) begin
                    r_err <= r_err + ERR_W'(1);
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out_byte <= w_bad ? SPACE_CODE : w_best_byte;
            r_out_bad  <= w_bad;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_corrected_byte = r_out_byte;
    assign o_not_printable  = r_out_bad;
    assign o_error_total    = r_err;

    // Filled cells always form an unbroken run from the head
    a_cells_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid & (w_valid + MAX_COPIES'(1))) == '0))
        else $error("cell chain has a gap");

    // While collecting, the fill count matches the filled cells
    a_fill_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> ($countones(w_valid) == int'(r_fill)))
        else $error("fill count out of step with cells");

    // The vote drains every cell before the result is formed
    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> (w_valid == '0))
        else $error("cells left after vote");

    // A finished block always reaches the output register next cycle
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |=> o_out_valid)
        else $error("result not presented");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import rmd_pkg::*;

    // Run length and pacing
    localparam int unsigned ITEMS      = 1650;
    localparam int unsigned LIMIT      = 500000;
    localparam int unsigned DRAIN_WAIT = 2 * MAX_COPIES_DEF + 4;

    // One decoded symbol as it leaves the output channel
    typedef struct packed {
        logic [BYTE_W-1:0] sym;
        logic              flag;
        logic [ERR_W-1:0]  total;
    } t_decoded;

    typedef enum logic {
        ROW_BYTE,
        ROW_CFG
    } t_row_kind;

    // One row of the directed table: a byte transfer or a block-length write.
    // Rows with typed set carry a hand-written result; the rest use the predictor.
    typedef struct packed {
        t_row_kind         kind;
        logic [BYTE_W-1:0] val;
        logic              typed;
        t_decoded          want;
    } t_step;

    localparam t_decoded NO_CHECK = '0;
    localparam int DIR_ROWS = 28;

    localparam t_step DIRECTED [0:DIR_ROWS-1] = '{
        // unanimous block at the reset length of three
        '{ROW_BYTE, 8'h41, 1'b0, NO_CHECK},
        '{ROW_BYTE, 8'h41, 1'b0, NO_CHECK},
        '{ROW_BYTE, 8'h41, 1'b1, '{8'h41, 1'b0, 32'd0}},
        // three-way tie: the signed minimum 0x80 wins and is replaced
        '{ROW_BYTE, 8'h41, 1'b0, NO_CHECK},
        '{ROW_BYTE, 8'h80, 1'b0, NO_CHECK},
        '{ROW_BYTE, 8'h7E, 1'b1, '{8'h20, 1'b1, 32'd1}},
        // all-ones majority is not printable
        '{ROW_BYTE, 8'hFF, 1'b0, NO_CHECK},
        '{ROW_BYTE, 8'h00, 1'b0, NO_CHECK},
        '{ROW_BYTE, 8'hFF, 1'b1, '{8'h20, 1'b1, 32'd2}},
        // lower printable bound wins
        '{ROW_BYTE, 8'h20, 1'b0, NO_CHECK},
        '{ROW_BYTE, 8'h7E, 1'b0, NO_CHECK},
        '{ROW_BYTE, 8'h20, 1'b0, NO_CHECK},
        // DEL just above the printable range
        '{ROW_BYTE, 8'h7F, 1'b0, NO_CHECK},
        '{ROW_BYTE, 8'h7F, 1'b0, NO_CHECK},
        '{ROW_BYTE, 8'h1F, 1'b1, '{8'h20, 1'b1, 32'd3}},
        // partial block, then dropped by a write of zero (acts as one)
        '{ROW_BYTE, 8'h55, 1'b0, NO_CHECK},
        '{ROW_CFG,  8'h00, 1'b0, NO_CHECK},
        '{ROW_BYTE, 8'h00, 1'b1, '{8'h20, 1'b1, 32'd4}},
        '{ROW_BYTE, 8'h7E, 1'b0, NO_CHECK},
        // fifteen clamps to the largest block; four-four tie goes to 0x61
        '{ROW_CFG,  8'h0F, 1'b0, NO_CHECK},
        '{ROW_BYTE, 8'h62, 1'b0, NO_CHECK},
        '{ROW_BYTE, 8'h61, 1'b0, NO_CHECK},
        '{ROW_BYTE, 8'h62, 1'b0, NO_CHECK},
        '{ROW_BYTE, 8'h61, 1'b0, NO_CHECK},
        '{ROW_BYTE, 8'h62, 1'b0, NO_CHECK},
        '{ROW_BYTE, 8'h61, 1'b0, NO_CHECK},
        '{ROW_BYTE, 8'h62, 1'b0, NO_CHECK},
        '{ROW_BYTE, 8'h61, 1'b1, '{8'h61, 1'b0, 32'd4}}
    };

    // Block lengths for the first random phases: extremes and clamped values
    localparam logic [CFG_W-1:0] SIZE_SWEEP [0:5] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd9, 4'd2};

    logic                i_clk               = 1'b0;
    logic                i_rst_n             = 1'b0;
    logic                i_cfg_valid         = 1'b0;
    logic                o_cfg_ready;
    logic [CFG_W-1:0]    i_copies_per_symbol = '0;
    logic                i_in_valid          = 1'b0;
    logic                o_in_ready;
    logic [BYTE_W-1:0]   i_data_byte         = '0;
    logic                o_out_valid;
    logic                i_out_ready         = 1'b0;
    logic [BYTE_W-1:0]   o_corrected_byte;
    logic                o_not_printable;
    logic [ERR_W-1:0]    o_error_total;

    repetition_majority_decoder u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_copies_per_symbol (i_copies_per_symbol),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_data_byte         (i_data_byte),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_corrected_byte    (o_corrected_byte),
        .o_not_printable     (o_not_printable),
        .o_error_total       (o_error_total)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Predictor state: block length, the copies of the current block, how many
    // copies match each one, the fill level and the replaced-block tally.
    logic [CFG_W-1:0]  cfg_copies;
    logic [BYTE_W-1:0] held_copy [MAX_COPIES_DEF];
    int unsigned       copy_hits [MAX_COPIES_DEF];
    int unsigned       fill_level;
    logic [ERR_W-1:0]  err_tally;

    t_decoded    decoded_q [$];    // decoded symbols still to come out
    int unsigned fail_cnt   = 0;
    int unsigned sent_cnt   = 0;
    int unsigned cycle_cnt  = 0;
    int unsigned burst_left = 0;
    int unsigned rx_left    = 0;
    bit          in_steady  = 1'b0;

    // Effective block length: zero acts as one, oversize clamps to the maximum
    function automatic int unsigned active_len();
        if (cfg_copies == 0) return 1;
        if (cfg_copies > MAX_COPIES_DEF) return MAX_COPIES_DEF;
        return cfg_copies;
    endfunction

    function automatic void drop_partial();
        fill_level = 0;
        foreach (copy_hits[i]) copy_hits[i] = 0;
    endfunction

    // Count one received copy into the block; on the last copy, vote.
    // Ties go to the smaller byte read as signed.
    function automatic void tally_copy(input logic [BYTE_W-1:0] b, output logic done,
                                       output t_decoded res);
        int unsigned n, pos, same, win_hits;
        logic [BYTE_W-1:0] win;
        logic bad;
        n    = active_len();
        pos  = fill_level;
        same = 1;
        done = 1'b0;
        res  = '0;
        if (pos >= n) begin
            drop_partial();
            pos = 0;
        end
        for (int unsigned i = 0; i < pos; i++) begin
            if (held_copy[i] == b) begin
                copy_hits[i]++;
                same++;
            end
        end
        held_copy[pos] = b;
        copy_hits[pos] = same;
        fill_level     = pos + 1;
        if (fill_level == n) begin
            win      = held_copy[0];
            win_hits = copy_hits[0];
            for (int unsigned i = 1; i < n; i++) begin
                if (copy_hits[i] > win_hits ||
                    (copy_hits[i] == win_hits && $signed(held_copy[i]) < $signed(win))) begin
                    win_hits = copy_hits[i];
                    win      = held_copy[i];
                end
            end
            bad = (win < PRINT_LOW) || (win > PRINT_HIGH);
            if (bad && err_tally != 32'hFFFF_FFFF) err_tally++;
            res.sym   = bad ? SPACE_CODE : win;
            res.flag  = bad;
            res.total = err_tally;
            done      = 1'b1;
            drop_partial();
        end
    endfunction

    // Mostly printable symbols, with a share of arbitrary bytes
    function automatic logic [BYTE_W-1:0] pick_symbol();
        if ($urandom_range(0, 3) == 0) return BYTE_W'($urandom);
        return BYTE_W'($urandom_range(PRINT_LOW, PRINT_HIGH));
    endfunction

    // Present one copy and hold it until the transfer; valid stays high after
    // it so a back-to-back copy can follow without a bubble.
    task automatic send_copy(input logic [BYTE_W-1:0] b, output logic done,
                             output t_decoded res);
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        tally_copy(b, done, res);
        sent_cnt++;
    endtask

    // Sender bursts: count down the burst, then drop valid for a random gap
    task automatic pace();
        if (in_steady) return;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(0, 23);
        end
    endtask

    // Write the block length only when idle: drain all results, then let a
    // possibly partial block settle before the transfer.
    task automatic write_copies(input logic [CFG_W-1:0] v);
        i_in_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_valid         <= 1'b1;
        i_copies_per_symbol <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cfg_copies = v;
        drop_partial();
    endtask

    // One block of count copies: a clear majority with noise, a two-symbol
    // contest that often ties, or plain random bytes.
    task automatic send_block(input int unsigned count);
        logic [BYTE_W-1:0] base, alt, b;
        int unsigned mode;
        logic done;
        t_decoded res;
        mode = $urandom_range(0, 9);
        base = pick_symbol();
        alt  = pick_symbol();
        for (int unsigned k = 0; k < count; k++) begin
            if (mode < 6)
                b = ($urandom_range(0, 3) == 0) ? BYTE_W'($urandom) : base;
            else if (mode < 8)
                b = ($urandom_range(0, 1) == 1) ? alt : base;
            else
                b = BYTE_W'($urandom);
            send_copy(b, done, res);
            if (done) decoded_q.push_back(res);
            pace();
        end
    endtask

    // Receiver: ready runs of random length (sometimes long), short stalls between
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_left     <= 0;
        end else if (rx_left == 0) begin
            if (!i_out_ready) begin
                i_out_ready <= 1'b1;
                rx_left     <= ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
            end else begin
                i_out_ready <= 1'b0;
                rx_left     <= $urandom_range(1, 6);
            end
        end else begin
            rx_left <= rx_left - 1;
        end
    end

    // Compare every output transfer with the oldest decoded symbol
    always @(posedge i_clk) begin : out_check
        t_decoded want, got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_corrected_byte, o_not_printable, o_error_total};
            if (decoded_q.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("%0t: result with none pending: byte %02h flag %0b total %0d",
                             $realtime, got.sym, got.flag, got.total);
            end else begin
                want = decoded_q.pop_front();
                if (got.sym !== want.sym || got.flag !== want.flag ||
                    got.total !== want.total) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display({"%0t: mismatch: exp byte %02h flag %0b total %0d, ",
                                  "got byte %02h flag %0b total %0d"},
                                 $realtime, want.sym, want.flag, want.total,
                                 got.sym, got.flag, got.total);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        logic done;
        t_decoded res;
        int unsigned phase, n;

        cfg_copies = CFG_RESET;
        err_tally  = '0;
        foreach (held_copy[i]) held_copy[i] = '0;
        drop_partial();

        // Hold reset, then release it for good
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (DIRECTED[r].kind == ROW_CFG) begin
                write_copies(DIRECTED[r].val[CFG_W-1:0]);
            end else begin
                send_copy(DIRECTED[r].val, done, res);
                if (done) decoded_q.push_back(DIRECTED[r].typed ? DIRECTED[r].want : res);
                pace();
            end
        end

        // Random phases: new block length, a run of blocks, sometimes a
        // trailing partial block that the next write drops.
        phase = 0;
        while (sent_cnt < ITEMS) begin
            write_copies(phase < 6 ? SIZE_SWEEP[phase] : CFG_W'($urandom_range(0, 15)));
            in_steady = ($urandom_range(0, 3) == 0);
            n = active_len();
            repeat ($urandom_range(4, 30)) send_block(n);
            if (n > 1 && $urandom_range(0, 2) == 0) send_block($urandom_range(1, n - 1));
            phase++;
        end

        // Drain and let the pipeline settle
        i_in_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_cnt == 0 && decoded_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
